### design/cst_pkg.sv
// Shared types and constants for the client session table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cst_pkg;

  // Number of table slots (1 to 64)
  localparam int MAX_CLIENTS = 16;
  localparam int IDX_W       = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int CNT_W       = $clog2(MAX_CLIENTS + 1);

  // Command queue between front and back; depth must be a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_CHECK  = 2'd2,
    REQ_LIST   = 2'd3
  } req_t;

  typedef struct packed {
    req_t        req;
    logic [31:0] ip;
    logic [15:0] port;
    logic        port_zero;
  } cmd_t;

endpackage

### design/cst_front.sv
// Front end of the client session table: accepts request transfers,
// decodes them into commands and buffers them in a short queue.
// Depends on cst_pkg.
`timescale 1ns / 1ps

module cst_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [47:0]   in_tdata,   // ip_addr[31:0], port_num[47:32]
  input  logic [1:0]    in_tuser,   // req_type[1:0]
  output logic          cmd_valid,
  output cst_pkg::cmd_t cmd,
  input  logic          cmd_ready
);
  import cst_pkg::*;

  cmd_t              q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] q_cnt_r;
  logic [QCNT_W-1:0] q_cnt_nxt;
  cmd_t              cmd_in;
  logic              push;
  logic              pop;

  always_comb begin
    cmd_in.req       = req_t'(in_tuser[1:0]);
    cmd_in.ip        = in_tdata[31:0];
    cmd_in.port      = in_tdata[47:32];
    cmd_in.port_zero = (in_tdata[47:32] == 16'd0);
  end

  assign in_tready = (q_cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign cmd_valid = (q_cnt_r != '0);
  assign cmd       = q_mem_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = cmd_valid && cmd_ready;

  // Pointers wrap on their own as the depth is a power of two
  assign wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
  assign rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;

  always_comb begin
    q_cnt_nxt = q_cnt_r;
    priority if (push && !pop) begin
      q_cnt_nxt = q_cnt_r + 1'b1;
    end else if (pop && !push) begin
      q_cnt_nxt = q_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      q_cnt_r  <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd_in;
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("command queue count beyond depth");

  a_empty_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
    (push && q_cnt_r == '0) |=>
      (cmd_valid && cmd.ip == $past(in_tdata[31:0]) && cmd.port == $past(in_tdata[47:32])))
    else $error("transfer into empty queue not presented at head");

endmodule

### design/cst_back.sv
// Back end of the client session table: slot storage, parallel match and
// first-free search, list scan and the result output register.
// Depends on cst_pkg.
`timescale 1ns / 1ps

module cst_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  cst_pkg::cmd_t cmd,
  output logic          cmd_ready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [63:0]   out_tdata,  // slot_index[5:0], entry_ip[37:6], entry_port[53:38],
                                    // client_count[60:54], space_available[61]
  output logic          out_tuser,  // success[0]
  output logic          out_tlast
);
  import cst_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } state_t;

  state_t             state_r;
  logic [31:0]        slot_ip_r   [MAX_CLIENTS];
  logic [15:0]        slot_port_r [MAX_CLIENTS];
  logic [MAX_CLIENTS-1:0] slot_valid_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic [IDX_W-1:0]   scan_idx_r;

  logic               out_valid_r;
  logic               out_success_r;
  logic [IDX_W-1:0]   out_slot_r;
  logic [31:0]        out_ip_r;
  logic [15:0]        out_port_r;
  logic [CNT_W-1:0]   out_count_r;
  logic               out_space_r;
  logic               out_last_r;

  logic               step;
  logic               pop;
  logic               list_step;
  logic               hit_any;
  logic [IDX_W-1:0]   hit_idx;
  logic               free_any;
  logic [IDX_W-1:0]   free_idx;
  logic               list_any;
  logic               list_more;
  logic [IDX_W-1:0]   list_idx;
  logic               add_go;
  logic               rem_go;

  logic               pop_success;
  logic [IDX_W-1:0]   pop_slot;
  logic [31:0]        pop_ip;
  logic [15:0]        pop_port;
  logic               pop_last;

  assign step      = !out_valid_r || out_tready;
  assign cmd_ready = (state_r == ST_IDLE) && step;
  assign pop       = cmd_valid && cmd_ready;
  assign list_step = (state_r == ST_LIST) && step;

  // Lowest matching slot and lowest free slot, all slots compared at once
  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = 0; i < MAX_CLIENTS; i++) begin
      if (!hit_any && slot_valid_r[i] && slot_ip_r[i] == cmd.ip &&
          slot_port_r[i] == cmd.port) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!free_any && !slot_valid_r[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // Next occupied slot at or above the scan position, and whether another follows
  always_comb begin
    list_any  = 1'b0;
    list_more = 1'b0;
    list_idx  = '0;
    for (int i = 0; i < MAX_CLIENTS; i++) begin
      if (slot_valid_r[i] && (i >= int'(scan_idx_r))) begin
        if (!list_any) begin
          list_any = 1'b1;
          list_idx = IDX_W'(i);
        end else begin
          list_more = 1'b1;
        end
      end
    end
  end

  assign add_go = pop && (cmd.req == REQ_ADD) && !cmd.port_zero && free_any;
  assign rem_go = pop && (cmd.req == REQ_REMOVE) && hit_any;

  always_comb begin
    count_nxt = count_r;
    priority if (add_go) begin
      count_nxt = count_r + 1'b1;
    end else if (rem_go) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Result of the command at the head of the queue
  always_comb begin
    pop_success = 1'b0;
    pop_slot    = '0;
    pop_ip      = cmd.ip;
    pop_port    = cmd.port;
    pop_last    = 1'b1;
    unique case (cmd.req)
      REQ_ADD: begin
        if (add_go) begin
          pop_success = 1'b1;
          pop_slot    = free_idx;
        end
      end
      REQ_REMOVE, REQ_CHECK: begin
        if (hit_any) begin
          pop_success = 1'b1;
          pop_slot    = hit_idx;
        end
      end
      REQ_LIST: begin
        // Scan position rests at zero, so the first entry goes out now
        if (list_any) begin
          pop_success = 1'b1;
          pop_slot    = list_idx;
          pop_ip      = slot_ip_r[list_idx];
          pop_port    = slot_port_r[list_idx];
          pop_last    = !list_more;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      slot_valid_r <= '0;
      count_r      <= '0;
      scan_idx_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (pop) begin
        out_valid_r   <= 1'b1;
        out_success_r <= pop_success;
        out_slot_r    <= pop_slot;
        out_ip_r      <= pop_ip;
        out_port_r    <= pop_port;
        out_count_r   <= count_nxt;
        out_space_r   <= (count_nxt < CNT_W'(MAX_CLIENTS));
        out_last_r    <= pop_last;
        if (add_go) begin
          slot_valid_r[free_idx] <= 1'b1;
        end
        if (rem_go) begin
          slot_valid_r[hit_idx] <= 1'b0;
        end
        if ((cmd.req == REQ_LIST) && list_more) begin
          state_r    <= ST_LIST;
          scan_idx_r <= list_idx + 1'b1;
        end
      end else if (list_step) begin
        out_valid_r   <= 1'b1;
        out_success_r <= 1'b1;
        out_slot_r    <= list_idx;
        out_ip_r      <= slot_ip_r[list_idx];
        out_port_r    <= slot_port_r[list_idx];
        out_count_r   <= count_r;
        out_space_r   <= (count_r < CNT_W'(MAX_CLIENTS));
        out_last_r    <= !list_more;
        if (list_more) begin
          scan_idx_r <= list_idx + 1'b1;
        end else begin
          state_r    <= ST_IDLE;
          scan_idx_r <= '0;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (add_go) begin
      slot_ip_r[free_idx]   <= cmd.ip;
      slot_port_r[free_idx] <= cmd.port;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_success_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_space_r, 7'(out_count_r), out_port_r, out_ip_r,
                       6'(out_slot_r)};

  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) == $countones(slot_valid_r))
    else $error("occupied count out of step with valid bits");

  a_list_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LIST) |-> list_any)
    else $error("list scan running with no entry left");

  a_fail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_success_r) |-> out_last_r)
    else $error("failed result not marked last");

endmodule

### design/client_session_table.sv
// Top level of the client session table: front end with command queue
// feeding the table back end. Depends on cst_pkg, cst_front and cst_back.
//
//   channel   dir  handshake              payload
//   in_*      in   in_tvalid/in_tready    tdata ip_addr, port_num; tuser req_type
//   out_*     out  out_tvalid/out_tready  tdata slot/ip/port/count/space; tuser success; tlast
//
// Add, remove and check complete in the back end as they leave the queue; every slot is matched
// in parallel and the result is registered in the same cycle.
// List emits one result per unstalled cycle, one per occupied slot, paced by out_tready.
// The front queue holds two requests and keeps taking transfers while the back end works.
// Reset (rst_n low, synchronous) clears valid bits, count, queue and output valid.
// A stalled output holds the back end; the queue then fills and drops in_tready.
`timescale 1ns / 1ps

module client_session_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // ip_addr[31:0], port_num[47:32]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // slot_index[5:0], entry_ip[37:6], entry_port[53:38],
                                  // client_count[60:54], space_available[61]
  output logic        out_tuser,  // success[0]
  output logic        out_tlast
);
  import cst_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  cst_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready)
  );

  cst_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_ready  (cmd_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

### bench/tb_client_session_table.sv
// Self-checking bench for client_session_table: queued stream driver, clocked monitor and a
// shadow endpoint table that predicts every reply. Depends on cst_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_client_session_table;
  import cst_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 144;
  localparam int POOL_SIZE    = 24;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    req_t        kind;
    logic [31:0] ip;
    logic [15:0] port;
  } session_req_t;

  typedef struct packed {
    logic        success;
    logic [5:0]  slot;
    logic [31:0] ip;
    logic [15:0] port;
    logic [6:0]  count;
    logic        space;
    logic        last;
  } session_reply_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  session_req_t   request_backlog[$];
  session_reply_t session_replies[$];

  // shadow copy of the table
  logic [31:0] tbl_ip    [MAX_CLIENTS];
  logic [15:0] tbl_port  [MAX_CLIENTS];
  logic        tbl_valid [MAX_CLIENTS];
  int          tbl_count = 0;

  int fault_count = 0;
  int cycle_count = 0;
  wire quiet_stretch = (cycle_count >= 200) && (cycle_count < 450);

  client_session_table u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #CLK_HALF clk = ~clk;

  function automatic void queue_request(req_t kind, logic [31:0] ip, logic [15:0] port);
    session_req_t r;
    r.kind = kind;
    r.ip   = ip;
    r.port = port;
    request_backlog = {request_backlog, r};
  endfunction

  function automatic void push_reply(logic ok, int slot, logic [31:0] ip, logic [15:0] port,
                                     logic last);
    session_reply_t r;
    r.success = ok;
    r.slot    = 6'(slot);
    r.ip      = ip;
    r.port    = port;
    r.count   = 7'(tbl_count);
    r.space   = (tbl_count < MAX_CLIENTS);
    r.last    = last;
    session_replies = {session_replies, r};
  endfunction

  // Update the shadow table and queue the replies one request causes
  task automatic apply_request(req_t kind, logic [31:0] ip, logic [15:0] port);
    int hit;
    int tail;
    hit  = -1;
    tail = -1;
    case (kind)
      REQ_ADD: begin
        if (port != 16'd0)
          for (int i = 0; i < MAX_CLIENTS; i++)
            if (hit < 0 && !tbl_valid[i]) hit = i;
        if (hit >= 0) begin
          tbl_ip[hit]    = ip;
          tbl_port[hit]  = port;
          tbl_valid[hit] = 1'b1;
          tbl_count++;
          push_reply(1'b1, hit, ip, port, 1'b1);
        end else begin
          push_reply(1'b0, 0, ip, port, 1'b1);
        end
      end
      REQ_REMOVE, REQ_CHECK: begin
        for (int i = 0; i < MAX_CLIENTS; i++)
          if (hit < 0 && tbl_valid[i] && tbl_ip[i] == ip && tbl_port[i] == port) hit = i;
        if (hit >= 0) begin
          if (kind == REQ_REMOVE) begin
            tbl_valid[hit] = 1'b0;
            tbl_count--;
          end
          push_reply(1'b1, hit, ip, port, 1'b1);
        end else begin
          push_reply(1'b0, 0, ip, port, 1'b1);
        end
      end
      default: begin
        for (int i = 0; i < MAX_CLIENTS; i++)
          if (tbl_valid[i]) tail = i;
        if (tail < 0) begin
          push_reply(1'b0, 0, ip, port, 1'b1);
        end else begin
          for (int i = 0; i < MAX_CLIENTS; i++)
            if (tbl_valid[i]) push_reply(1'b1, i, tbl_ip[i], tbl_port[i], i == tail);
        end
      end
    endcase
  endtask

  task automatic check_reply();
    session_reply_t want;
    session_reply_t got;
    got.success = out_tuser;
    got.slot    = out_tdata[5:0];
    got.ip      = out_tdata[37:6];
    got.port    = out_tdata[53:38];
    got.count   = out_tdata[60:54];
    got.space   = out_tdata[61];
    got.last    = out_tlast;
    if (session_replies.size() == 0) begin
      fault_count++;
      if (fault_count <= REPORT_MAX)
        $display("%0t: unexpected reply ok=%0b slot=%0d ip=%h port=%h cnt=%0d space=%0b last=%0b",
                 $time, got.success, got.slot, got.ip, got.port, got.count, got.space,
                 got.last);
    end else begin
      want = session_replies.pop_front();
      if (want.success !== got.success || want.slot !== got.slot || want.ip !== got.ip ||
          want.port !== got.port || want.count !== got.count || want.space !== got.space ||
          want.last !== got.last) begin
        fault_count++;
        if (fault_count <= REPORT_MAX)
          $display({"%0t: reply mismatch\n  exp ok=%0b slot=%0d ip=%h port=%h cnt=%0d ",
                    "space=%0b last=%0b\n  got ok=%0b slot=%0d ip=%h port=%h cnt=%0d ",
                    "space=%0b last=%0b"},
                   $time, want.success, want.slot, want.ip, want.port, want.count,
                   want.space, want.last, got.success, got.slot, got.ip, got.port,
                   got.count, got.space, got.last);
      end
    end
  endtask

  // Driver: present the next request once the current one has transferred
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (request_backlog.size() != 0 && (quiet_stretch || $urandom_range(0, 99) >= 15)) begin
        in_tdata  <= {request_backlog[0].port, request_backlog[0].ip};
        in_tuser  <= request_backlog[0].kind;
        in_tvalid <= 1'b1;
        void'(request_backlog.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= quiet_stretch || ($urandom_range(0, 99) >= 15);
  end

  // Monitor: check replies first, then predict from the request that transfers now
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) check_reply();
      if (in_tvalid && in_tready) apply_request(req_t'(in_tuser), in_tdata[31:0],
                                                in_tdata[47:32]);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [31:0] pool_ip   [POOL_SIZE];
    logic [15:0] pool_port [POOL_SIZE];
    logic        filling;
    int          pick;
    int          roll;
    int          add_weight;
    req_t        kind;
    logic [31:0] ip;
    logic [15:0] port;

    for (int i = 0; i < MAX_CLIENTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_ip[i]    = '0;
      tbl_port[i]  = '0;
    end
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_ip[i]   = $urandom;
      pool_port[i] = 16'($urandom_range(1, 65535));
    end
    pool_ip[0] = 32'h0000_0000;
    pool_port[0] = 16'h0001;
    pool_ip[1] = 32'hFFFF_FFFF;
    pool_port[1] = 16'hFFFF;

    // Directed: empty list, zero port, fill with a duplicate, full table, removal and refill
    queue_request(REQ_LIST,   32'h0000_0000, 16'h0000);
    queue_request(REQ_ADD,    32'hFFFF_FFFF, 16'h0000);
    queue_request(REQ_REMOVE, 32'hFFFF_FFFF, 16'h0000);
    queue_request(REQ_ADD,    pool_ip[0], pool_port[0]);
    queue_request(REQ_ADD,    pool_ip[1], pool_port[1]);
    queue_request(REQ_ADD,    pool_ip[1], pool_port[1]);
    for (int i = 2; i < MAX_CLIENTS - 1; i++)
      queue_request(REQ_ADD, pool_ip[i], pool_port[i]);
    queue_request(REQ_ADD,    32'h1234_5678, 16'h8000);
    queue_request(REQ_LIST,   32'h0000_0000, 16'h0000);
    queue_request(REQ_REMOVE, pool_ip[1], pool_port[1]);
    queue_request(REQ_CHECK,  pool_ip[1], pool_port[1]);
    queue_request(REQ_CHECK,  pool_ip[1], 16'hFFFE);
    queue_request(REQ_ADD,    pool_ip[MAX_CLIENTS - 1], pool_port[MAX_CLIENTS - 1]);
    queue_request(REQ_REMOVE, 32'h0000_0000, 16'h0002);

    // Random: alternate fill and drain phases over a small endpoint pool
    filling = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) filling = ~filling;
      add_weight = filling ? 50 : 15;
      pick = $urandom_range(0, POOL_SIZE - 1);
      ip   = pool_ip[pick];
      port = pool_port[pick];
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        kind = req_t'($urandom_range(0, 3));
        ip   = $urandom;
        port = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom);
      end else if (roll < 10 + add_weight) begin
        kind = REQ_ADD;
      end else if (roll < 20 + add_weight) begin
        kind = REQ_LIST;
      end else if (roll < 35 + add_weight) begin
        kind = REQ_CHECK;
      end else begin
        kind = REQ_REMOVE;
      end
      // near miss: one flipped bit in address or port
      if ((kind == REQ_REMOVE || kind == REQ_CHECK) && $urandom_range(0, 4) == 0) begin
        if ($urandom_range(0, 1) == 0) ip ^= 32'(1 << $urandom_range(0, 31));
        else port ^= 16'(1 << $urandom_range(0, 15));
      end
      queue_request(kind, ip, port);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (request_backlog.size() != 0 || in_tvalid || session_replies.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fault_count == 0 && session_replies.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### client_session_table.f
design/cst_pkg.sv
design/cst_front.sv
design/cst_back.sv
design/client_session_table.sv
bench/tb_client_session_table.sv
